/* hw/rtl/ntpr_pkg.sv */
// Shared types and constants for the NTP server reply builder.
// No dependencies; every other file in hw/rtl imports this package.
package ntpr_pkg;

    typedef struct packed {
        logic [7:0]  req_byte;
        logic        req_last;
        logic [11:0] utc_year;
        logic [3:0]  utc_month;
        logic [4:0]  utc_day;
        logic [4:0]  utc_hour;
        logic [5:0]  utc_minute;
        logic [5:0]  utc_second;
        logic [9:0]  utc_millis;
    } req_t;

    typedef struct packed {
        logic [7:0] resp_byte;
        logic [5:0] resp_index;
        logic       resp_last;
    } resp_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } utc_time_t;

    // Request that qualified for a reply, as handed to the time converter
    typedef struct packed {
        utc_time_t   tm;
        logic [63:0] client_stamp;
    } stamp_job_t;

    // Everything the byte emitter needs beyond the server settings
    typedef struct packed {
        logic [63:0] ts;
        logic [63:0] client_stamp;
    } reply_desc_t;

    typedef struct packed {
        logic [7:0]  stratum;
        logic [7:0]  poll;
        logic [7:0]  precision;
        logic [31:0] ref_id;
    } srv_cfg_t;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_STRATUM   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRECISION = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REF_ID    = 8'd3;

    localparam logic [7:0]  RST_STRATUM   = 8'd1;
    localparam logic [7:0]  RST_POLL      = 8'd6;
    localparam logic [7:0]  RST_PRECISION = 8'hEC;
    localparam logic [31:0] RST_REF_ID    = 32'h4750_5300;

    localparam logic [5:0] REQ_LEN     = 6'd48;
    localparam logic [5:0] STAMP_FIRST = 6'd40;
    localparam logic [5:0] LAST_INDEX  = 6'd47;
    localparam logic [2:0] MODE_CLIENT = 3'd3;
    localparam logic [7:0] LI_VN_MODE  = 8'h24;

    localparam logic [9:0]  MS_MAX          = 10'd999;
    localparam logic [12:0] YEAR_SHIFT      = 13'd400;
    localparam logic [31:0] DAY_BIAS        = 32'd865565;
    localparam logic [31:0] NTP_UNIX_OFFSET = 32'd2208988800;
    localparam logic [31:0] SECS_PER_DAY    = 32'd86400;
    // ceil(2^49 / 1000): fraction = (ms * FRAC_MULT) >> 17
    localparam logic [39:0] FRAC_MULT       = 40'd562949953422;
    // floor(x / 25) = (x * 1311) >> 15 for x below 1124
    localparam logic [21:0] DIV25_MULT      = 22'd1311;

    // Days from 1 March to the first of the month (year starts in March)
    function automatic logic [8:0] month_offset(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* hw/rtl/ntpr_req_parser.sv */
// Request byte tracker: byte count, mode bits and client transmit stamp.
// Flags a qualifying request end and registers its time fields. Uses ntpr_pkg.
module ntpr_req_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  ntpr_pkg::req_t     in_data,
    output logic               reply_start,
    output logic               job_valid,
    output ntpr_pkg::stamp_job_t job
);
    import ntpr_pkg::*;

    logic [5:0]  byte_count_reg, byte_count_next;
    logic [2:0]  mode_reg, mode_next;
    logic [63:0] stamp_reg, stamp_next;
    logic        job_valid_reg;
    stamp_job_t  job_reg;

    always_comb begin
        byte_count_next = byte_count_reg;
        mode_next       = mode_reg;
        stamp_next      = stamp_reg;
        reply_start     = 1'b0;
        if (in_fire) begin
            if (byte_count_reg < REQ_LEN) begin
                if (byte_count_reg == 6'd0) begin
                    mode_next = in_data.req_byte[2:0];
                end
                if (byte_count_reg >= STAMP_FIRST) begin
                    stamp_next = {stamp_reg[55:0], in_data.req_byte};
                end
                byte_count_next = byte_count_reg + 6'd1;
            end
            if (in_data.req_last) begin
                reply_start     = (byte_count_next == REQ_LEN) && (mode_next == MODE_CLIENT);
                byte_count_next = 6'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            mode_reg       <= '0;
            stamp_reg      <= '0;
            job_valid_reg  <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            mode_reg       <= mode_next;
            stamp_reg      <= stamp_next;
            job_valid_reg  <= reply_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (reply_start) begin
            job_reg.tm.year     <= in_data.utc_year;
            job_reg.tm.month    <= in_data.utc_month;
            job_reg.tm.day      <= in_data.utc_day;
            job_reg.tm.hour     <= in_data.utc_hour;
            job_reg.tm.minute   <= in_data.utc_minute;
            job_reg.tm.second   <= in_data.utc_second;
            job_reg.tm.millis   <= in_data.utc_millis;
            job_reg.client_stamp <= stamp_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

/* hw/rtl/ntpr_time_conv.sv */
// Four-stage civil time to NTP timestamp converter (seconds since 1900, 2^-32 fraction).
// Free-running pipeline, no stall. Uses ntpr_pkg.
module ntpr_time_conv (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    input  ntpr_pkg::stamp_job_t  job,
    output logic                  desc_valid,
    output ntpr_pkg::reply_desc_t desc
);
    import ntpr_pkg::*;

    // stage 1: month clamp, shifted year, day of year, h/m/s, fraction partial products
    logic        v1_reg;
    logic [12:0] yy1_reg, yy1_next;
    logic [9:0]  doy1_reg, doy1_next;
    logic [16:0] hms1_reg, hms1_next;
    logic [41:0] pplo1_reg, pplo1_next;
    logic [17:0] pphi1_reg, pphi1_next;
    logic [63:0] cs1_reg;

    // stage 2: year day count, century term, fraction
    logic        v2_reg;
    logic [20:0] ydays2_reg, ydays2_next;
    logic [5:0]  q100_2_reg, q100_2_next;
    logic [9:0]  doy2_reg;
    logic [16:0] hms2_reg;
    logic [31:0] frac2_reg, frac2_next;
    logic [63:0] cs2_reg;

    // stage 3: day number relative to 1970
    logic        v3_reg;
    logic [31:0] days3_reg, days3_next;
    logic [16:0] hms3_reg;
    logic [31:0] frac3_reg;
    logic [63:0] cs3_reg;

    // stage 4: seconds word
    logic        v4_reg;
    logic [31:0] secs4_reg, secs4_next;
    logic [31:0] frac4_reg;
    logic [63:0] cs4_reg;

    logic [3:0]  mon_c;
    logic [9:0]  ms_c;
    logic [10:0] yq;
    logic [49:0] frac_sum;

    always_comb begin
        if (job.tm.month == 4'd0) begin
            mon_c = 4'd1;
        end else if (job.tm.month > 4'd12) begin
            mon_c = 4'd12;
        end else begin
            mon_c = job.tm.month;
        end
        ms_c = (job.tm.millis > MS_MAX) ? MS_MAX : job.tm.millis;

        // Jan and Feb count as months of the previous year
        yy1_next   = 13'(job.tm.year) + YEAR_SHIFT - ((mon_c <= 4'd2) ? 13'd1 : 13'd0);
        doy1_next  = 10'(month_offset(mon_c)) + 10'(job.tm.day) - 10'd1;
        hms1_next  = 17'(job.tm.hour) * 17'd3600 + 17'(job.tm.minute) * 17'd60
                   + 17'(job.tm.second);
        pplo1_next = 42'(ms_c) * 42'(FRAC_MULT[31:0]);
        pphi1_next = 18'(ms_c) * 18'(FRAC_MULT[39:32]);
    end

    always_comb begin
        yq          = yy1_reg[12:2];
        q100_2_next = 6'((22'(yq) * DIV25_MULT) >> 15);
        ydays2_next = 21'(yy1_reg) * 21'd365 + 21'(yq);
        frac_sum    = 50'(pplo1_reg) + {pphi1_reg, 32'd0};
        frac2_next  = frac_sum[48:17];
    end

    always_comb begin
        days3_next = 32'(ydays2_reg) - 32'(q100_2_reg) + 32'(q100_2_reg[5:2])
                   + {{22{doy2_reg[9]}}, doy2_reg} - DAY_BIAS;
        secs4_next = 32'(days3_reg * SECS_PER_DAY) + 32'(hms3_reg) + NTP_UNIX_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= job_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        yy1_reg    <= yy1_next;
        doy1_reg   <= doy1_next;
        hms1_reg   <= hms1_next;
        pplo1_reg  <= pplo1_next;
        pphi1_reg  <= pphi1_next;
        cs1_reg    <= job.client_stamp;

        ydays2_reg <= ydays2_next;
        q100_2_reg <= q100_2_next;
        doy2_reg   <= doy1_reg;
        hms2_reg   <= hms1_reg;
        frac2_reg  <= frac2_next;
        cs2_reg    <= cs1_reg;

        days3_reg  <= days3_next;
        hms3_reg   <= hms2_reg;
        frac3_reg  <= frac2_reg;
        cs3_reg    <= cs2_reg;

        secs4_reg  <= secs4_next;
        frac4_reg  <= frac3_reg;
        cs4_reg    <= cs3_reg;
    end

    assign desc_valid        = v4_reg;
    assign desc.ts           = {secs4_reg, frac4_reg};
    assign desc.client_stamp = cs4_reg;

endmodule

/* hw/rtl/ntpr_reply_gen.sv */
// Reply emitter: two-entry descriptor queue, byte index counter, output register.
// Builds each of the 48 reply bytes from the descriptor and server settings. Uses ntpr_pkg.
module ntpr_reply_gen (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  desc_valid,
    input  ntpr_pkg::reply_desc_t desc,
    input  ntpr_pkg::srv_cfg_t    srv_cfg,
    output logic                  desc_done,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ntpr_pkg::resp_t       m_data
);
    import ntpr_pkg::*;

    reply_desc_t fifo_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic [5:0]  idx_reg, idx_next;
    logic        m_valid_reg, m_valid_next;
    resp_t       m_data_reg;
    reply_desc_t head;
    logic        load;
    logic [7:0]  byte_sel;

    assign head = fifo_reg[rd_ptr_reg];
    assign load = (count_reg != 2'd0) && (!m_valid_reg || m_ready);
    assign desc_done = load && (idx_reg == LAST_INDEX);

    always_comb begin
        if (idx_reg == 6'd0) begin
            byte_sel = LI_VN_MODE;
        end else if (idx_reg == 6'd1) begin
            byte_sel = srv_cfg.stratum;
        end else if (idx_reg == 6'd2) begin
            byte_sel = srv_cfg.poll;
        end else if (idx_reg == 6'd3) begin
            byte_sel = srv_cfg.precision;
        end else if (idx_reg inside {[6'd12:6'd15]}) begin
            byte_sel = srv_cfg.ref_id[{~idx_reg[1:0], 3'b000} +: 8];
        end else if (idx_reg inside {[6'd24:6'd31]}) begin
            byte_sel = head.client_stamp[{~idx_reg[2:0], 3'b000} +: 8];
        end else if (idx_reg inside {[6'd16:6'd23], [6'd32:6'd47]}) begin
            // reference, receive and transmit stamps all carry the current time
            byte_sel = head.ts[{~idx_reg[2:0], 3'b000} +: 8];
        end else begin
            byte_sel = 8'd0;
        end
    end

    always_comb begin
        count_next = count_reg + (desc_valid ? 2'd1 : 2'd0) - (desc_done ? 2'd1 : 2'd0);
        idx_next   = idx_reg;
        if (load) begin
            idx_next = desc_done ? 6'd0 : idx_reg + 6'd1;
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (desc_valid) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (desc_done) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (desc_valid) begin
            fifo_reg[wr_ptr_reg] <= desc;
        end
        if (load) begin
            m_data_reg.resp_byte  <= byte_sel;
            m_data_reg.resp_index <= idx_reg;
            m_data_reg.resp_last  <= (idx_reg == LAST_INDEX);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hw/rtl/ntp_server_reply_builder.sv */
// Top level of the NTP server reply builder: settings registers, reply credit count.
// Instantiates ntpr_req_parser, ntpr_time_conv and ntpr_reply_gen; uses ntpr_pkg.
//
//   channel   dir   handshake          payload
//   s_        in    s_valid/s_ready    ntpr_pkg::req_t, one request byte + current UTC
//   m_        out   m_valid/m_ready    ntpr_pkg::resp_t, one reply byte
//   cfg_      in    cfg_valid/cfg_ready cfg_index, cfg_data (settings write)
//
// One request byte is taken per cycle while s_ready is high. A qualifying request
// end gives 48 reply bytes. The job register loads at the accepting edge; four
// converter stages, the descriptor queue and the output register follow before
// m_valid rises. Then one byte per cycle while m_ready stays high.
// s_ready drops only for a closing request byte while two replies are queued or
// in flight. Reset is synchronous on aresetn low; settings return to their defaults.
// cfg_ready is always high.
module ntp_server_reply_builder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ntpr_pkg::req_t                       s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ntpr_pkg::resp_t                      m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ntpr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ntpr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ntpr_pkg::*;

    srv_cfg_t    srv_cfg_reg;
    logic [1:0]  pending_reg, pending_next;
    logic        s_fire;
    logic        reply_start;
    logic        job_valid;
    stamp_job_t  job;
    logic        desc_valid;
    reply_desc_t desc;
    logic        desc_done;

    // only a closing byte can start a reply, so only that one is held back
    assign s_ready   = ~(pending_reg[1] & s_data.req_last);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // replies accepted but not yet fully loaded into the output register
    assign pending_next = pending_reg + (reply_start ? 2'd1 : 2'd0)
                        - (desc_done ? 2'd1 : 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg           <= '0;
            srv_cfg_reg.stratum   <= RST_STRATUM;
            srv_cfg_reg.poll      <= RST_POLL;
            srv_cfg_reg.precision <= RST_PRECISION;
            srv_cfg_reg.ref_id    <= RST_REF_ID;
        end else begin
            pending_reg <= pending_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_STRATUM:   srv_cfg_reg.stratum   <= cfg_data[7:0];
                    CFG_POLL:      srv_cfg_reg.poll      <= cfg_data[7:0];
                    CFG_PRECISION: srv_cfg_reg.precision <= cfg_data[7:0];
                    CFG_REF_ID:    srv_cfg_reg.ref_id    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    ntpr_req_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (s_fire),
        .in_data     (s_data),
        .reply_start (reply_start),
        .job_valid   (job_valid),
        .job         (job)
    );

    ntpr_time_conv u_time (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (job_valid),
        .job        (job),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    ntpr_reply_gen u_reply (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .srv_cfg    (srv_cfg_reg),
        .desc_done  (desc_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

/* hw/rtl/ntpr_checker.sv */
// Port-level checks for ntp_server_reply_builder, attached by bind.
// Depends on ntpr_pkg and the top level's port list.
module ntpr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input ntpr_pkg::req_t                   s_data,
    input logic                             m_valid,
    input logic                             m_ready,
    input ntpr_pkg::resp_t                  m_data,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [ntpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [ntpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ntpr_pkg::*;

    // a stalled reply byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("reply transaction changed while stalled");

    // bytes of one reply leave back to back, in index order
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.resp_last
        |=> m_valid && (m_data.resp_index == $past(m_data.resp_index) + 6'd1))
        else $error("reply byte index out of sequence");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.resp_last == (m_data.resp_index == LAST_INDEX)))
        else $error("last marker not on final reply byte");

    a_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.resp_index == 6'd0) |-> (m_data.resp_byte == LI_VN_MODE))
        else $error("reply header byte wrong");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("reply valid after reset");

endmodule

bind ntp_server_reply_builder ntpr_checker u_ntpr_checker (.*);

/* sim/ntp_server_reply_builder_test.sv */
// Self-checking testbench for ntp_server_reply_builder: request bytes in, reply bytes out.
// Predicts each 48-byte reply from its own model of the block; uses types from ntpr_pkg.
// Needs only the RTL under hw/rtl; no files, arguments or seeds are read.
module ntp_server_reply_builder_test;
    import ntpr_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 96;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned MAX_SHOWN     = 10;

    localparam logic [2:0] MODE_RESERVED = 3'd0;
    localparam logic [2:0] MODE_SERVER   = 3'd4;
    localparam logic [2:0] MODE_PRIVATE  = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'hFF;

    // reply layout
    localparam int unsigned REF_ID_AT  = 12;
    localparam int unsigned REF_TS_AT  = 16;
    localparam int unsigned ORIG_TS_AT = 24;
    localparam int unsigned RECV_TS_AT = 32;
    localparam int unsigned XMIT_TS_AT = 40;

    localparam longint SECS_1900_TO_1970 = 64'sd2208988800;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    resp_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted block state
    logic [7:0]  srv_stratum   = RST_STRATUM;
    logic [7:0]  srv_poll      = RST_POLL;
    logic [7:0]  srv_precision = RST_PRECISION;
    logic [31:0] srv_ref_id    = RST_REF_ID;
    logic [5:0]  bytes_seen    = '0;
    logic [2:0]  req_mode      = '0;
    logic [63:0] client_stamp  = '0;

    resp_t reply_bytes_due[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit feed_steady = 1'b0;
    bit drain_steady = 1'b0;

    ntp_server_reply_builder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // NTP seconds, wrapped to 32 bits, via days from the civil date
    function automatic logic [31:0] ntp_seconds(input req_t r);
        longint yr, mon, day, hr, mi, se;
        longint yy, era, yoe, mp, doy, doe, days, secs;
        yr  = r.utc_year;
        mon = r.utc_month;
        day = r.utc_day;
        hr  = r.utc_hour;
        mi  = r.utc_minute;
        se  = r.utc_second;
        if (mon < 1)
            mon = 1;
        if (mon > 12)
            mon = 12;
        yy   = yr + 400 - ((mon <= 2) ? 1 : 0);
        era  = yy / 400;
        yoe  = yy - era * 400;
        mp   = (mon + 9) % 12;
        doy  = (153 * mp + 2) / 5 + day - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468 - 146097;
        secs = days * 86400 + hr * 3600 + mi * 60 + se + SECS_1900_TO_1970;
        return secs[31:0];
    endfunction

    function automatic logic [31:0] ntp_fraction(input req_t r);
        logic [63:0] ms;
        ms = 64'(r.utc_millis);
        if (ms > 64'(MS_MAX))
            ms = 64'(MS_MAX);
        return 32'((ms << 32) / 64'd1000);
    endfunction

    task automatic store_setting(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_STRATUM:   srv_stratum = data[7:0];
            CFG_POLL:      srv_poll = data[7:0];
            CFG_PRECISION: srv_precision = data[7:0];
            CFG_REF_ID:    srv_ref_id = data;
            default: ;
        endcase
    endtask

    task automatic take_request_byte(input req_t r);
        logic [7:0]  pkt [48];
        logic [63:0] ts;
        logic [7:0]  t;
        resp_t       due;
        if (bytes_seen < REQ_LEN) begin
            if (bytes_seen == 0)
                req_mode = r.req_byte[2:0];
            if (bytes_seen >= STAMP_FIRST)
                client_stamp = {client_stamp[55:0], r.req_byte};
            bytes_seen++;
        end
        if (r.req_last) begin
            if (bytes_seen == REQ_LEN && req_mode == MODE_CLIENT) begin
                ts = {ntp_seconds(r), ntp_fraction(r)};
                foreach (pkt[i])
                    pkt[i] = 8'h00;
                pkt[0] = LI_VN_MODE;
                pkt[1] = srv_stratum;
                pkt[2] = srv_poll;
                pkt[3] = srv_precision;
                for (int i = 0; i < 4; i++)
                    pkt[REF_ID_AT + i] = srv_ref_id[31 - 8 * i -: 8];
                for (int i = 0; i < 8; i++) begin
                    t = ts[63 - 8 * i -: 8];
                    pkt[REF_TS_AT + i]  = t;
                    pkt[ORIG_TS_AT + i] = client_stamp[63 - 8 * i -: 8];
                    pkt[RECV_TS_AT + i] = t;
                    pkt[XMIT_TS_AT + i] = t;
                end
                for (int i = 0; i < int'(REQ_LEN); i++) begin
                    due.resp_byte  = pkt[i];
                    due.resp_index = 6'(i);
                    due.resp_last  = (6'(i) == LAST_INDEX);
                    reply_bytes_due.push_back(due);
                end
            end
            bytes_seen = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                store_setting(cfg_index, cfg_data);
            if (s_valid && s_ready)
                take_request_byte(s_data);
        end
    end

    always @(posedge aclk) begin : check_reply
        resp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reply_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected reply byte %02h index %0d last %0b",
                             m_data.resp_byte, m_data.resp_index, m_data.resp_last);
            end else begin
                want = reply_bytes_due.pop_front();
                if (m_data.resp_byte !== want.resp_byte || m_data.resp_index !== want.resp_index
                        || m_data.resp_last !== want.resp_last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("reply mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                                 want.resp_byte, want.resp_index, want.resp_last,
                                 m_data.resp_byte, m_data.resp_index, m_data.resp_last);
                end
            end
        end
    end

    // sink back-pressure
    initial begin
        int unsigned hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                hold = pick_gap(drain_steady);
            end
        end
    end

    // returns at the edge that accepts the transaction; valid stays up until the next call
    task automatic push_byte(input req_t item);
        int unsigned gap;
        gap = pick_gap(feed_steady);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic utc_time_t make_time(input int y, input int mo, input int d, input int h,
                                            input int mi, input int s, input int ms);
        utc_time_t t;
        t.year   = 12'(y);
        t.month  = 4'(mo);
        t.day    = 5'(d);
        t.hour   = 5'(h);
        t.minute = 6'(mi);
        t.second = 6'(s);
        t.millis = 10'(ms);
        return t;
    endfunction

    // mostly plausible dates, otherwise any bit pattern
    function automatic utc_time_t pick_time();
        utc_time_t t;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        t = raw[$bits(utc_time_t)-1:0];
        if ($urandom_range(0, 3) != 0)
            t = make_time($urandom_range(1970, 2105), $urandom_range(1, 12),
                          $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                          $urandom_range(0, 59), $urandom_range(0, 999));
        return t;
    endfunction

    // random bytes and time on every item; the stamp only on the closing one
    task automatic send_request(input int unsigned len, input logic [2:0] mode,
                                input utc_time_t stamp);
        req_t item;
        logic [63:0] raw;
        for (int unsigned i = 0; i < len; i++) begin
            raw = {$urandom, $urandom};
            item = raw[$bits(req_t)-1:0];
            item.req_last = (i == len - 1);
            if (i == 0)
                item.req_byte[2:0] = mode;
            if (item.req_last) begin
                item.utc_year   = stamp.year;
                item.utc_month  = stamp.month;
                item.utc_day    = stamp.day;
                item.utc_hour   = stamp.hour;
                item.utc_minute = stamp.minute;
                item.utc_second = stamp.second;
                item.utc_millis = stamp.millis;
            end
            push_byte(item);
        end
    endtask

    task automatic drain_replies();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reply_bytes_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // upper data bits of the byte-wide settings are junk and must be dropped
    task automatic write_all_settings(input logic [7:0] stratum, input logic [7:0] poll,
                                      input logic [7:0] precision, input logic [31:0] ref_id);
        write_setting(CFG_STRATUM, {24'($urandom), stratum});
        write_setting(CFG_POLL, {24'($urandom), poll});
        write_setting(CFG_PRECISION, {24'($urandom), precision});
        write_setting(CFG_REF_ID, ref_id);
    endtask

    function automatic logic [7:0] pick_setting8(input logic [7:0] lo, input logic [7:0] hi);
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return 8'($urandom);
    endfunction

    task automatic test_plain_reply();
        // default settings straight out of reset
        send_request(int'(REQ_LEN), MODE_CLIENT, make_time(2024, 6, 15, 12, 34, 56, 500));
        // full rate on both sides
        feed_steady = 1'b1;
        drain_steady = 1'b1;
        send_request(int'(REQ_LEN), MODE_CLIENT, pick_time());
        feed_steady = 1'b0;
        drain_steady = 1'b0;
        drain_replies();
    endtask

    task automatic test_cut_short();
        send_request(int'(REQ_LEN) - 1, MODE_CLIENT, pick_time());
        send_request(1, MODE_CLIENT, pick_time());
        drain_replies();
    endtask

    task automatic test_overlong();
        send_request(int'(REQ_LEN) + 1, MODE_CLIENT, pick_time());
        drain_replies();
    endtask

    task automatic test_other_modes();
        int unsigned pick;
        logic [2:0] mode;
        pick = $urandom_range(0, 2);
        mode = (pick == 0) ? MODE_RESERVED : ((pick == 1) ? MODE_SERVER : MODE_PRIVATE);
        send_request(int'(REQ_LEN), mode, pick_time());
        drain_replies();
    endtask

    task automatic test_clock_extremes();
        // full-rate input against a stalling sink, so the two replies queue up
        feed_steady = 1'b1;
        send_request(int'(REQ_LEN), MODE_CLIENT, make_time(0, 0, 0, 0, 0, 0, 0));
        send_request(int'(REQ_LEN), MODE_CLIENT, make_time(4095, 15, 31, 31, 63, 63, 1023));
        feed_steady = 1'b0;
        drain_replies();
    endtask

    task automatic test_settings();
        write_all_settings(8'h00, 8'hFF, 8'h80, 32'hFFFF_0000);
        // writes to an unmapped index leave everything alone
        write_setting(CFG_UNUSED, $urandom);
        send_request(int'(REQ_LEN), MODE_CLIENT, pick_time());
        drain_replies();
    endtask

    task automatic test_random_traffic();
        int unsigned sent, next_cfg, len, kind;
        logic [2:0] mode;
        sent = 0;
        next_cfg = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_cfg) begin
                drain_replies();
                write_all_settings(pick_setting8(8'h00, 8'hFF), pick_setting8(8'h00, 8'hFF),
                                   pick_setting8(8'h80, 8'h7F),
                                   ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
                feed_steady = ($urandom_range(0, 3) == 0);
                drain_steady = ($urandom_range(0, 3) == 0);
                next_cfg += 120;
            end
            kind = $urandom_range(0, 99);
            len = int'(REQ_LEN);
            mode = MODE_CLIENT;
            if (kind >= 93) begin
                // noise
                len = $urandom_range(1, 64);
                mode = 3'($urandom_range(0, 7));
            end else if (kind >= 86) begin
                do mode = 3'($urandom_range(0, 7)); while (mode == MODE_CLIENT);
            end else if (kind >= 78) begin
                len = $urandom_range(1, int'(REQ_LEN) - 1);
            end else if (kind >= 70) begin
                len = $urandom_range(int'(REQ_LEN) + 1, 64);
            end
            send_request(len, mode, pick_time());
            sent += len;
        end
        feed_steady = 1'b0;
        drain_steady = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_plain_reply();
        test_cut_short();
        test_overlong();
        test_other_modes();
        test_clock_extremes();
        test_settings();
        test_random_traffic();
        drain_replies();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
